// ===== design/aapp_pkg.sv =====
// Package for the box penetration push pipeline.
// Holds shared constants: default coordinate width, scale factor, axis and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aapp_pkg;

    // Default coordinate width (signed Q16.8 at 24 bits)
    localparam int COORD_BITS_DEFAULT = 24;

    // Push scale: overlap * 51 / 256, rounded to nearest
    localparam int SCALE_NUM   = 51;
    localparam int SCALE_SHIFT = 8;
    localparam int SCALE_GROW  = 6;   // bits needed for the product by SCALE_NUM
    localparam int ROUND_BIAS  = 1 << (SCALE_SHIFT - 1);

    localparam int NUM_AXES = 3;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_CENTER_X = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_CENTER_Y = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_CENTER_Z = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_HALF_X   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_HALF_Y   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_HALF_Z   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_DIST    = 3'd6;

endpackage

`default_nettype wire

// ===== design/aabb_penetration_push_top.sv =====
// Top level of the box penetration push block: configuration registers and four-stage pipeline.
// Depends on aapp_pkg, aapp_prep, aapp_square, aapp_pick and aapp_push.
`timescale 1ns / 1ps
`default_nettype none

// Resolves a hit between the block's own axis-aligned box (center and half extents held in
// configuration registers) and one target box per item. An item hits when the squared center
// distance is strictly below gate_distance squared and the boxes overlap on every axis
// (touching faces count). On a hit, the axis with the smallest overlap is chosen (X only if
// strictly smallest, else Y if below Z, else Z) and the push on that axis is
// round(overlap * 51 / 256), negative when the own center lies strictly below the target
// center; the other two axes read zero. Without a hit all outputs are zero. Coordinates are
// signed fixed point (Q16.8 at the default 24 bits). The pipeline takes one item per cycle
// while the output is not stalled and passes each item through four register stages, which
// are set by the distance squaring multipliers in stage 2, the wide distance sum and
// compare in stage 3 and the scale multiply in stage 4. Each stage holds its item while the
// next one is full, so bubbles close up under a stalled output. Write configuration only
// while no items are in flight; writes to an unused index are dropped.

module aabb_penetration_push_top
    import aapp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [COORD_BITS-1:0]       cfg_data,
    // input items
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [COORD_BITS-1:0]       other_center_x,
    input  wire logic [COORD_BITS-1:0]       other_center_y,
    input  wire logic [COORD_BITS-1:0]       other_center_z,
    input  wire logic [COORD_BITS-2:0]       other_half_x,
    input  wire logic [COORD_BITS-2:0]       other_half_y,
    input  wire logic [COORD_BITS-2:0]       other_half_z,
    // result items
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             hit,
    output logic [COORD_BITS-1:0]            push_x,
    output logic [COORD_BITS-1:0]            push_y,
    output logic [COORD_BITS-1:0]            push_z
);

    // Configuration registers
    logic [COORD_BITS-1:0] own_center_x_reg;
    logic [COORD_BITS-1:0] own_center_y_reg;
    logic [COORD_BITS-1:0] own_center_z_reg;
    logic [COORD_BITS-2:0] own_half_x_reg;
    logic [COORD_BITS-2:0] own_half_y_reg;
    logic [COORD_BITS-2:0] own_half_z_reg;
    logic [COORD_BITS-1:0] gate_distance_reg;

    logic [NUM_AXES-1:0][COORD_BITS-1:0] own_center;
    logic [NUM_AXES-1:0][COORD_BITS-2:0] own_half;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] other_center;
    logic [NUM_AXES-1:0][COORD_BITS-2:0] other_half;

    // Stage 1 -> 2
    logic                                  s1_valid;
    logic                                  s1_ready;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]   s1_abs_dist;
    logic [NUM_AXES-1:0]                   s1_below;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]   s1_half_sum;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]   s1_half_min2;

    // Stage 2 -> 3
    logic                                    s2_valid;
    logic                                    s2_ready;
    logic [NUM_AXES-1:0][2*COORD_BITS-1:0]   s2_dist_sq;
    logic [2*COORD_BITS-1:0]                 s2_gate_sq;
    logic [NUM_AXES-1:0]                     s2_overlap;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]     s2_ov_len;
    logic [NUM_AXES-1:0]                     s2_below;

    // Stage 3 -> 4
    logic                     s3_valid;
    logic                     s3_ready;
    logic                     s3_hit;
    logic [1:0]               s3_axis;
    logic [COORD_BITS-1:0]    s3_ov_sel;
    logic                     s3_below_sel;

    // Register writes; unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_center_x_reg  <= '0;
            own_center_y_reg  <= '0;
            own_center_z_reg  <= '0;
            own_half_x_reg    <= '0;
            own_half_y_reg    <= '0;
            own_half_z_reg    <= '0;
            gate_distance_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OWN_CENTER_X: own_center_x_reg  <= cfg_data;
                REG_OWN_CENTER_Y: own_center_y_reg  <= cfg_data;
                REG_OWN_CENTER_Z: own_center_z_reg  <= cfg_data;
                REG_OWN_HALF_X:   own_half_x_reg    <= cfg_data[COORD_BITS-2:0];
                REG_OWN_HALF_Y:   own_half_y_reg    <= cfg_data[COORD_BITS-2:0];
                REG_OWN_HALF_Z:   own_half_z_reg    <= cfg_data[COORD_BITS-2:0];
                REG_GATE_DIST:    gate_distance_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Gather axes into arrays, X at index 0
    assign own_center   = {own_center_z_reg, own_center_y_reg, own_center_x_reg};
    assign own_half     = {own_half_z_reg, own_half_y_reg, own_half_x_reg};
    assign other_center = {other_center_z, other_center_y, other_center_x};
    assign other_half   = {other_half_z, other_half_y, other_half_x};

    aapp_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .own_center   (own_center),
        .own_half     (own_half),
        .other_center (other_center),
        .other_half   (other_half),
        .out_valid    (s1_valid),
        .out_ready    (s1_ready),
        .abs_dist     (s1_abs_dist),
        .below        (s1_below),
        .half_sum     (s1_half_sum),
        .half_min2    (s1_half_min2)
    );

    aapp_square #(
        .COORD_BITS (COORD_BITS)
    ) u_square (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s1_valid),
        .in_ready      (s1_ready),
        .abs_dist      (s1_abs_dist),
        .below         (s1_below),
        .half_sum      (s1_half_sum),
        .half_min2     (s1_half_min2),
        .gate_distance (gate_distance_reg),
        .out_valid     (s2_valid),
        .out_ready     (s2_ready),
        .dist_sq       (s2_dist_sq),
        .gate_sq       (s2_gate_sq),
        .overlap       (s2_overlap),
        .ov_len        (s2_ov_len),
        .below_out     (s2_below)
    );

    aapp_pick #(
        .COORD_BITS (COORD_BITS)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .dist_sq   (s2_dist_sq),
        .gate_sq   (s2_gate_sq),
        .overlap   (s2_overlap),
        .ov_len    (s2_ov_len),
        .below     (s2_below),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .hit       (s3_hit),
        .axis      (s3_axis),
        .ov_sel    (s3_ov_sel),
        .below_sel (s3_below_sel)
    );

    aapp_push #(
        .COORD_BITS (COORD_BITS)
    ) u_push (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .hit_in    (s3_hit),
        .axis      (s3_axis),
        .ov_sel    (s3_ov_sel),
        .below_sel (s3_below_sel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .push_x    (push_x),
        .push_y    (push_y),
        .push_z    (push_z)
    );

    // A miss carries no push
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> ((push_x == '0) && (push_y == '0) && (push_z == '0)))
        else $error("push nonzero on a miss");

    // At most one axis carries a push
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones({push_x != '0, push_y != '0, push_z != '0}) <= 1))
        else $error("push on more than one axis");

    // An open output lets every stage advance, so input is never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is open");

    // A stalled stage 3 item must still be there next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid && !s3_ready) |=> (s3_valid && $stable(s3_ov_sel) && $stable(s3_axis)))
        else $error("stage 3 item lost under stall");

endmodule

`default_nettype wire

// ===== design/aapp_prep.sv =====
// Stage 1 of the box penetration push pipeline: center distance, below flags and half-extent sums.
// Depends on aapp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aapp_prep
    import aapp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [NUM_AXES-1:0][COORD_BITS-1:0]   own_center,
    input  wire logic [NUM_AXES-1:0][COORD_BITS-2:0]   own_half,
    input  wire logic [NUM_AXES-1:0][COORD_BITS-1:0]   other_center,
    input  wire logic [NUM_AXES-1:0][COORD_BITS-2:0]   other_half,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [NUM_AXES-1:0][COORD_BITS-1:0]        abs_dist,
    output logic [NUM_AXES-1:0]                        below,
    output logic [NUM_AXES-1:0][COORD_BITS-1:0]        half_sum,
    output logic [NUM_AXES-1:0][COORD_BITS-1:0]        half_min2
);

    logic                                  valid_reg;
    logic                                  valid_next;
    logic [NUM_AXES-1:0][COORD_BITS:0]     diff;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]   abs_dist_next;
    logic [NUM_AXES-1:0]                   below_next;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]   half_sum_next;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]   half_min2_next;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]   abs_dist_reg;
    logic [NUM_AXES-1:0]                   below_reg;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]   half_sum_reg;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]   half_min2_reg;
    logic [NUM_AXES-1:0][COORD_BITS:0]     diff_neg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            // target minus own, one bit wider than a coordinate
            diff[a]     = {other_center[a][COORD_BITS-1], other_center[a]}
                        - {own_center[a][COORD_BITS-1], own_center[a]};
            diff_neg[a] = -diff[a];
            abs_dist_next[a] = diff[a][COORD_BITS] ? diff_neg[a][COORD_BITS-1:0]
                                                   : diff[a][COORD_BITS-1:0];
            // own center strictly below target center
            below_next[a] = !diff[a][COORD_BITS] && (diff[a] != '0);
            half_sum_next[a] = {1'b0, own_half[a]} + {1'b0, other_half[a]};
            half_min2_next[a] = (own_half[a] < other_half[a]) ? {own_half[a], 1'b0}
                                                              : {other_half[a], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            abs_dist_reg  <= abs_dist_next;
            below_reg     <= below_next;
            half_sum_reg  <= half_sum_next;
            half_min2_reg <= half_min2_next;
        end
    end

    assign out_valid = valid_reg;
    assign abs_dist  = abs_dist_reg;
    assign below     = below_reg;
    assign half_sum  = half_sum_reg;
    assign half_min2 = half_min2_reg;

endmodule

`default_nettype wire

// ===== design/aapp_square.sv =====
// Stage 2 of the box penetration push pipeline: squared distances and per-axis overlap.
// Depends on aapp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aapp_square
    import aapp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [NUM_AXES-1:0][COORD_BITS-1:0]   abs_dist,
    input  wire logic [NUM_AXES-1:0]                   below,
    input  wire logic [NUM_AXES-1:0][COORD_BITS-1:0]   half_sum,
    input  wire logic [NUM_AXES-1:0][COORD_BITS-1:0]   half_min2,
    input  wire logic [COORD_BITS-1:0]                 gate_distance,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [NUM_AXES-1:0][2*COORD_BITS-1:0]      dist_sq,
    output logic [2*COORD_BITS-1:0]                    gate_sq,
    output logic [NUM_AXES-1:0]                        overlap,
    output logic [NUM_AXES-1:0][COORD_BITS-1:0]        ov_len,
    output logic [NUM_AXES-1:0]                        below_out
);

    logic                                    valid_reg;
    logic                                    valid_next;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]     slack;
    logic [NUM_AXES-1:0][2*COORD_BITS-1:0]   dist_sq_next;
    logic [NUM_AXES-1:0]                     overlap_next;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]     ov_len_next;
    logic [2*COORD_BITS-1:0]                 gate_sq_next;
    logic [NUM_AXES-1:0][2*COORD_BITS-1:0]   dist_sq_reg;
    logic [2*COORD_BITS-1:0]                 gate_sq_reg;
    logic [NUM_AXES-1:0]                     overlap_reg;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]     ov_len_reg;
    logic [NUM_AXES-1:0]                     below_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        gate_sq_next = {{COORD_BITS{1'b0}}, gate_distance}
                     * {{COORD_BITS{1'b0}}, gate_distance};
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dist_sq_next[a] = {{COORD_BITS{1'b0}}, abs_dist[a]}
                            * {{COORD_BITS{1'b0}}, abs_dist[a]};
            // touching faces count as overlapping
            overlap_next[a] = (abs_dist[a] <= half_sum[a]);
            // overlap length: clip by the shorter box when one contains the other
            slack[a]        = half_sum[a] - abs_dist[a];
            ov_len_next[a]  = (slack[a] < half_min2[a]) ? slack[a] : half_min2[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            dist_sq_reg <= dist_sq_next;
            gate_sq_reg <= gate_sq_next;
            overlap_reg <= overlap_next;
            ov_len_reg  <= ov_len_next;
            below_reg   <= below;
        end
    end

    assign out_valid = valid_reg;
    assign dist_sq   = dist_sq_reg;
    assign gate_sq   = gate_sq_reg;
    assign overlap   = overlap_reg;
    assign ov_len    = ov_len_reg;
    assign below_out = below_reg;

endmodule

`default_nettype wire

// ===== design/aapp_pick.sv =====
// Stage 3 of the box penetration push pipeline: distance gate, hit and axis choice.
// Depends on aapp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aapp_pick
    import aapp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [NUM_AXES-1:0][2*COORD_BITS-1:0] dist_sq,
    input  wire logic [2*COORD_BITS-1:0]               gate_sq,
    input  wire logic [NUM_AXES-1:0]                   overlap,
    input  wire logic [NUM_AXES-1:0][COORD_BITS-1:0]   ov_len,
    input  wire logic [NUM_AXES-1:0]                   below,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       hit,
    output logic [1:0]                                 axis,
    output logic [COORD_BITS-1:0]                      ov_sel,
    output logic                                       below_sel
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [2*COORD_BITS+1:0]   dist_sum;
    logic                      hit_next;
    logic [1:0]                axis_next;
    logic [COORD_BITS-1:0]     ov_sel_next;
    logic                      below_sel_next;
    logic                      hit_reg;
    logic [1:0]                axis_reg;
    logic [COORD_BITS-1:0]     ov_sel_reg;
    logic                      below_sel_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        dist_sum = {2'b00, dist_sq[0]} + {2'b00, dist_sq[1]} + {2'b00, dist_sq[2]};
        hit_next = (&overlap) && (dist_sum < {2'b00, gate_sq});
        // X only if strictly smallest, else Y if below Z, else Z
        if ((ov_len[0] < ov_len[1]) && (ov_len[0] < ov_len[2]))
        begin
            axis_next      = AXIS_X;
            ov_sel_next    = ov_len[0];
            below_sel_next = below[0];
        end
        else if (ov_len[1] < ov_len[2])
        begin
            axis_next      = AXIS_Y;
            ov_sel_next    = ov_len[1];
            below_sel_next = below[1];
        end
        else
        begin
            axis_next      = AXIS_Z;
            ov_sel_next    = ov_len[2];
            below_sel_next = below[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            hit_reg       <= hit_next;
            axis_reg      <= axis_next;
            ov_sel_reg    <= ov_sel_next;
            below_sel_reg <= below_sel_next;
        end
    end

    assign out_valid = valid_reg;
    assign hit       = hit_reg;
    assign axis      = axis_reg;
    assign ov_sel    = ov_sel_reg;
    assign below_sel = below_sel_reg;

endmodule

`default_nettype wire

// ===== design/aapp_push.sv =====
// Stage 4 of the box penetration push pipeline: scale, sign and output register.
// Depends on aapp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aapp_push
    import aapp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     hit_in,
    input  wire logic [1:0]               axis,
    input  wire logic [COORD_BITS-1:0]    ov_sel,
    input  wire logic                     below_sel,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          hit,
    output logic [COORD_BITS-1:0]         push_x,
    output logic [COORD_BITS-1:0]         push_y,
    output logic [COORD_BITS-1:0]         push_z
);

    localparam int ProdBits = COORD_BITS + SCALE_GROW;
    localparam int MagBits  = ProdBits - SCALE_SHIFT;

    logic                     valid_reg;
    logic                     valid_next;
    logic [ProdBits-1:0]      prod;
    logic [MagBits-1:0]       mag;
    logic [COORD_BITS-1:0]    mag_ext;
    logic [COORD_BITS-1:0]    value;
    logic [COORD_BITS-1:0]    push_x_next;
    logic [COORD_BITS-1:0]    push_y_next;
    logic [COORD_BITS-1:0]    push_z_next;
    logic                     hit_reg;
    logic [COORD_BITS-1:0]    push_x_reg;
    logic [COORD_BITS-1:0]    push_y_reg;
    logic [COORD_BITS-1:0]    push_z_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        prod    = {{SCALE_GROW{1'b0}}, ov_sel} * ProdBits'(SCALE_NUM)
                + ProdBits'(ROUND_BIAS);
        mag     = prod[ProdBits-1:SCALE_SHIFT];
        mag_ext = {{(COORD_BITS-MagBits){1'b0}}, mag};
        // push away from the target: negative when own center lies below
        value   = below_sel ? -mag_ext : mag_ext;
        push_x_next = '0;
        push_y_next = '0;
        push_z_next = '0;
        if (hit_in)
        begin
            case (axis)
                AXIS_X:  push_x_next = value;
                AXIS_Y:  push_y_next = value;
                AXIS_Z:  push_z_next = value;
                default: push_z_next = value;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            hit_reg    <= hit_in;
            push_x_reg <= push_x_next;
            push_y_reg <= push_y_next;
            push_z_reg <= push_z_next;
        end
    end

    assign out_valid = valid_reg;
    assign hit       = hit_reg;
    assign push_x    = push_x_reg;
    assign push_y    = push_y_reg;
    assign push_z    = push_z_reg;

endmodule

`default_nettype wire
